// ===== hdl/lmph_pkg.sv =====
// package for the level meter with peak hold
// widths, register codes, zone codes and the per-channel state word
// no dependencies
package lmph_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 18;
    localparam int LEVEL_W    = 17;
    localparam int HOLD_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int ZONE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int IN_BITS  = CH_W + SAMPLE_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = CH_W + 2 * LEVEL_W + ZONE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(65536);

    localparam logic [COUNT_W-1:0] COUNT_RST     = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] COUNT_MIN     = COUNT_W'(2);
    localparam logic [LEVEL_W-1:0] RELEASE_RST   = LEVEL_W'(2294);
    localparam logic [LEVEL_W-1:0] PEAK_REL_RST  = LEVEL_W'(983);
    localparam logic [HOLD_W-1:0]  HOLD_RST      = HOLD_W'(18);
    localparam logic [LEVEL_W-1:0] GREEN_RST     = LEVEL_W'(16462);
    localparam logic [LEVEL_W-1:0] YELLOW_RST    = LEVEL_W'(46396);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_RELEASE_STEP  = 3'd1,
        REG_PEAK_RELEASE  = 3'd2,
        REG_HOLD_UPDATES  = 3'd3,
        REG_GREEN_LIMIT   = 3'd4,
        REG_YELLOW_LIMIT  = 3'd5
    } cfg_reg_t;

    typedef enum logic [ZONE_W-1:0] {
        ZONE_NONE   = 2'd0,
        ZONE_GREEN  = 2'd1,
        ZONE_YELLOW = 2'd2,
        ZONE_RED    = 2'd3
    } zone_t;

    typedef struct packed {
        logic [HOLD_W-1:0]  hold;
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] shown;
    } chan_state_t;

endpackage

// ===== hdl/lmph_chan_mem.sv =====
// per-channel state memory: synchronous read into a read data register
// valid bit per entry so a clear takes effect at once; uses lmph_pkg
module lmph_chan_mem #(
    parameter int DEPTH = lmph_pkg::MAX_CHANNELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clr,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output lmph_pkg::chan_state_t      rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  lmph_pkg::chan_state_t      wr_data
);
    import lmph_pkg::*;

    chan_state_t            mem [DEPTH];
    logic [DEPTH-1:0]       valid_reg;
    chan_state_t            rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/level_meter_peak_hold_top.sv =====
// level meter with peak hold: top level
// config registers, update pipeline and output register; uses lmph_pkg, lmph_chan_mem
//
// usage:
//   s_tdata carries one channel update word; m_tdata/m_tuser return exactly one
//   result word per input word, in order. config writes go through cfg_we,
//   cfg_index and cfg_data; the user must make them only while the block is
//   idle, as the block does not enforce it. writing the channel count clears
//   the state of all channels at once. an accepted word is registered in the
//   update stage, then in the output register. throughput: one word per cycle
//   while m_tready does not stall the output. state is read from memory when a
//   word is accepted and written back when it leaves the update stage; a word
//   for the same channel accepted then takes that state from a forwarding register.
//   reset: config registers return to their defaults, all channel state reads
//   as zero, both pipeline stages are empty.
//   stall: the output register holds its word while m_tready is low; the
//   update stage keeps one more word, after which s_tready drops.
//   a channel at or beyond the channel count returns m_tuser high with zero
//   levels and leaves the state alone.
module level_meter_peak_hold_top #(
    parameter int MAX_CHANNELS = lmph_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // channel [2:0], sample_level [20:3], zero fill
    input  logic [lmph_pkg::IN_W-1:0]       s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // channel_out [2:0], shown_level [19:3], peak_level [36:20], zone [38:37], zero fill
    output logic [lmph_pkg::OUT_W-1:0]      m_tdata,
    // bad_channel [0]
    output logic                            m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [lmph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmph_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lmph_pkg::*;

    localparam int AW = $clog2(MAX_CHANNELS);

    // config registers
    logic [COUNT_W-1:0] count_reg;
    logic [LEVEL_W-1:0] release_reg;
    logic [LEVEL_W-1:0] peak_rel_reg;
    logic [HOLD_W-1:0]  hold_upd_reg;
    logic [LEVEL_W-1:0] green_reg;
    logic [LEVEL_W-1:0] yellow_reg;
    logic [6:0]         count_wide;
    logic [6:0]         count_clamp;
    logic               clr_chan;

    // input word
    logic [CH_W-1:0]     in_ch;
    logic [SAMPLE_W-1:0] in_sample;
    logic [LEVEL_W-1:0]  in_clamped;
    logic                accept;

    // update stage
    logic               s1_valid_reg;
    logic [CH_W-1:0]    s1_ch_reg;
    logic [LEVEL_W-1:0] s1_sample_reg;
    logic               s1_fwd_reg;
    logic               s1_fwd_next;
    chan_state_t        wr_state_reg;
    chan_state_t        rd_state;
    chan_state_t        old_state;
    chan_state_t        new_state;
    logic               s1_bad;
    logic               out_free;
    logic               s1_adv;
    logic               wr_en;
    logic [LEVEL_W:0]   shown_diff;
    logic [LEVEL_W:0]   peak_diff;
    logic [LEVEL_W-1:0] shown_fall;
    logic [LEVEL_W-1:0] peak_fall;
    zone_t              zone_new;

    // output register
    logic               out_valid_reg;
    logic [CH_W-1:0]    out_ch_reg;
    logic [LEVEL_W-1:0] out_shown_reg;
    logic [LEVEL_W-1:0] out_peak_reg;
    zone_t              out_zone_reg;
    logic               out_bad_reg;

    // ---------------- configuration ----------------
    assign clr_chan = cfg_we && (cfg_reg_t'(cfg_index) == REG_CHANNEL_COUNT);

    always_comb
    begin
        count_wide = {3'b000, cfg_data[COUNT_W-1:0]};
        if (count_wide < 7'(COUNT_MIN))
        begin
            count_clamp = 7'(COUNT_MIN);
        end
        else if (count_wide > 7'(MAX_CHANNELS))
        begin
            count_clamp = 7'(MAX_CHANNELS);
        end
        else
        begin
            count_clamp = count_wide;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= COUNT_RST;
            release_reg  <= RELEASE_RST;
            peak_rel_reg <= PEAK_REL_RST;
            hold_upd_reg <= HOLD_RST;
            green_reg    <= GREEN_RST;
            yellow_reg   <= YELLOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CHANNEL_COUNT: count_reg    <= count_clamp[COUNT_W-1:0];
                REG_RELEASE_STEP:  release_reg  <= cfg_data;
                REG_PEAK_RELEASE:  peak_rel_reg <= cfg_data;
                REG_HOLD_UPDATES:  hold_upd_reg <= cfg_data[HOLD_W-1:0];
                REG_GREEN_LIMIT:   green_reg    <= cfg_data;
                REG_YELLOW_LIMIT:  yellow_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ---------------- input ----------------
    assign in_ch     = s_tdata[CH_W-1:0];
    assign in_sample = s_tdata[CH_W +: SAMPLE_W];

    always_comb
    begin
        if (in_sample[SAMPLE_W-1])
        begin
            in_clamped = '0;
        end
        else if (in_sample[LEVEL_W-1:0] > FULL_SCALE)
        begin
            in_clamped = FULL_SCALE;
        end
        else
        begin
            in_clamped = in_sample[LEVEL_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign s1_bad   = {1'b0, s1_ch_reg} >= count_reg;
    assign wr_en    = s1_adv && !s1_bad;

    // previous word writes this channel at the same edge as our read
    assign s1_fwd_next = wr_en && (s1_ch_reg == in_ch);

    lmph_chan_mem #(
        .DEPTH (MAX_CHANNELS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (clr_chan),
        .rd_en   (accept),
        .rd_addr (AW'(in_ch)),
        .rd_data (rd_state),
        .wr_en   (wr_en),
        .wr_addr (AW'(s1_ch_reg)),
        .wr_data (new_state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_fwd_reg   <= s1_fwd_next;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg     <= in_ch;
            s1_sample_reg <= in_clamped;
        end
        if (wr_en)
        begin
            wr_state_reg <= new_state;
        end
    end

    // ---------------- update ----------------
    assign old_state  = s1_fwd_reg ? wr_state_reg : rd_state;
    assign shown_diff = {1'b0, old_state.shown} - {1'b0, release_reg};
    assign peak_diff  = {1'b0, old_state.peak} - {1'b0, peak_rel_reg};
    assign shown_fall = shown_diff[LEVEL_W] ? '0 : shown_diff[LEVEL_W-1:0];
    assign peak_fall  = peak_diff[LEVEL_W] ? '0 : peak_diff[LEVEL_W-1:0];

    always_comb
    begin
        new_state = old_state;
        if (s1_sample_reg >= old_state.shown)
        begin
            new_state.shown = s1_sample_reg;
        end
        else if (shown_fall > s1_sample_reg)
        begin
            new_state.shown = shown_fall;
        end
        else
        begin
            new_state.shown = s1_sample_reg;
        end

        priority if (s1_sample_reg >= old_state.peak)
        begin
            new_state.peak = s1_sample_reg;
            new_state.hold = hold_upd_reg;
        end
        else if (old_state.hold != '0)
        begin
            new_state.hold = old_state.hold - HOLD_W'(1);
        end
        else if (peak_fall > new_state.shown)
        begin
            new_state.peak = peak_fall;
        end
        else
        begin
            new_state.peak = new_state.shown;
        end
    end

    always_comb
    begin
        priority if (new_state.shown == '0)
        begin
            zone_new = ZONE_NONE;
        end
        else if (new_state.shown > yellow_reg)
        begin
            zone_new = ZONE_RED;
        end
        else if (new_state.shown > green_reg)
        begin
            zone_new = ZONE_YELLOW;
        end
        else
        begin
            zone_new = ZONE_GREEN;
        end
    end

    // ---------------- output ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_ch_reg  <= s1_ch_reg;
            out_bad_reg <= s1_bad;
            if (s1_bad)
            begin
                out_shown_reg <= '0;
                out_peak_reg  <= '0;
                out_zone_reg  <= ZONE_NONE;
            end
            else
            begin
                out_shown_reg <= new_state.shown;
                out_peak_reg  <= new_state.peak;
                out_zone_reg  <= zone_new;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_bad_reg;
    assign m_tdata  = {(OUT_W - OUT_BITS)'(0), out_zone_reg, out_peak_reg,
                       out_shown_reg, out_ch_reg};

endmodule

// ===== hdl/lmph_checker.sv =====
// port-level checks for the level meter with peak hold
// bound to level_meter_peak_hold_top; uses lmph_pkg
module lmph_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [lmph_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tuser
);
    import lmph_pkg::*;

    logic [LEVEL_W-1:0] shown;
    logic [LEVEL_W-1:0] peak;
    logic [ZONE_W-1:0]  zone;

    assign shown = m_tdata[CH_W +: LEVEL_W];
    assign peak  = m_tdata[CH_W + LEVEL_W +: LEVEL_W];
    assign zone  = m_tdata[CH_W + 2 * LEVEL_W +: ZONE_W];

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // bad channel carries zero levels
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> shown == '0 && peak == '0 && zone == ZONE_NONE)
        else $error("bad channel word carries levels");

    // peak never below shown level
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> peak >= shown)
        else $error("peak below shown level");

    // zone none exactly when shown level is zero
    a_zone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> ((zone == ZONE_NONE) == (shown == '0)))
        else $error("zone does not match shown level");

endmodule

bind level_meter_peak_hold_top lmph_checker u_lmph_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
